// ===== rtl/json_string_unescape_top_macros.svh =====
// assertion macros shared by the json string unescape rtl
// depends on clk and rst_n being visible in the module that uses them
`ifndef JSON_STRING_UNESCAPE_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPE_TOP_MACROS_SVH

// property that holds at every edge outside reset
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must be followed by another in the next cycle
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
// types, codes and helper functions for the json string unescape block
// no dependencies
package jsu_pkg;

  // input word: one byte of string body or end of text
  typedef struct packed {
    logic       op;
    logic [7:0] text_byte;
  } jsu_in_t;

  // result word: one decoded byte with status
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       last;
  } jsu_out_t;

  // status codes
  localparam logic [2:0] ST_RUN    = 3'd0;
  localparam logic [2:0] ST_CLOSED = 3'd1;
  localparam logic [2:0] ST_CTRL   = 3'd2;
  localparam logic [2:0] ST_ESC    = 3'd3;
  localparam logic [2:0] ST_UNI    = 3'd4;
  localparam logic [2:0] ST_UNTERM = 3'd5;

  // operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // characters of interest
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // queue depth between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // most bytes one input word can produce
  localparam int MAX_BYTES = 6;

  // utf-8 of the replacement character, first byte in slot 0
  localparam logic [2:0][7:0] REPL_UTF8 = {8'hbd, 8'hbf, 8'hef};
  localparam logic [20:0] CP_REPL = 21'h00fffd;

  // escape decoding phases
  typedef enum logic [11:0] {
    PH_NORMAL   = 12'b0000_0000_0001,
    PH_ESC      = 12'b0000_0000_0010,
    PH_HEX0     = 12'b0000_0000_0100,
    PH_HEX1     = 12'b0000_0000_1000,
    PH_HEX2     = 12'b0000_0001_0000,
    PH_HEX3     = 12'b0000_0010_0000,
    PH_HELD     = 12'b0000_0100_0000,
    PH_HELD_ESC = 12'b0000_1000_0000,
    PH_LOW0     = 12'b0001_0000_0000,
    PH_LOW1     = 12'b0010_0000_0000,
    PH_LOW2     = 12'b0100_0000_0000,
    PH_LOW3     = 12'b1000_0000_0000
  } jsu_phase_t;

  // one queue entry: all bytes produced by one input word
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;     // zero means a single empty result
    logic [2:0]                status;
  } jsu_entry_t;

  // queue handshake between modules
  typedef struct packed {
    logic valid;
    logic ready;
  } jsu_hs_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
  } jsu_utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } jsu_hex_t;

  typedef struct packed {
    logic [2:0] status;
    logic       emit;
    logic [7:0] data;
    logic       to_esc;
  } jsu_plain_t;

  typedef struct packed {
    logic [2:0] status;
    logic       emit;
    logic [7:0] data;
    logic       to_hex;
  } jsu_escd_t;

  // utf-8 encoding of a code point
  function automatic jsu_utf8_t utf8_enc(input logic [20:0] cp);
    jsu_utf8_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.len      = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.len      = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.len      = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.len      = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  // hex digit value
  function automatic jsu_hex_t hex_digit(input logic [7:0] b);
    jsu_hex_t r;
    r.ok  = 1'b1;
    r.val = b[3:0];
    if (b inside {[8'h30:8'h39]}) begin
      r.val = b[3:0];
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r.val = 4'(b[2:0] + 3'd1) + 4'd8;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // plain text byte
  function automatic jsu_plain_t plain_byte(input logic [7:0] b);
    jsu_plain_t r;
    r.status = ST_RUN;
    r.emit   = 1'b0;
    r.data   = b;
    r.to_esc = 1'b0;
    if (b == CH_QUOTE) begin
      r.status = ST_CLOSED;
    end else if (b < CH_SPACE) begin
      r.status = ST_CTRL;
    end else if (b == CH_BSLASH) begin
      r.to_esc = 1'b1;
    end else begin
      r.emit = 1'b1;
    end
    return r;
  endfunction

  // character after a backslash
  function automatic jsu_escd_t esc_byte(input logic [7:0] b);
    jsu_escd_t r;
    r.status = ST_RUN;
    r.emit   = 1'b1;
    r.data   = b;
    r.to_hex = 1'b0;
    case (b)
      CH_QUOTE, CH_BSLASH, CH_SLASH: r.data = b;
      8'h62: r.data = 8'h08;
      8'h66: r.data = 8'h0c;
      8'h6e: r.data = 8'h0a;
      8'h72: r.data = 8'h0d;
      8'h74: r.data = 8'h09;
      CH_U: begin
        r.emit   = 1'b0;
        r.to_hex = 1'b1;
      end
      default: begin
        r.emit   = 1'b0;
        r.status = ST_ESC;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/jsu_front.sv =====
// front end: accepts input words, tracks escape state, builds queue entries
// depends on jsu_pkg and json_string_unescape_top_macros.svh
`include "json_string_unescape_top_macros.svh"

module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  jsu_in_t    in_data,
  output jsu_entry_t q_entry,
  output jsu_hs_t    q_push,
  input  logic       q_ready
);

  jsu_phase_t  phase_r, phase_nxt;
  logic [15:0] hex_r, hex_nxt;
  logic [9:0]  held_r, held_nxt;

  logic        push;
  logic [7:0]  b;
  logic [2:0]  st;
  logic        pre;
  logic        raw_en;
  logic [7:0]  raw;
  logic        cp_en;
  logic [20:0] cp;
  jsu_hex_t    hx;
  logic [2:0]  gather_st;
  logic [15:0] hex_shift;
  jsu_plain_t  pl;
  jsu_escd_t   es;
  jsu_utf8_t   enc;
  logic [2:0]  b_len;
  logic [3:0][7:0] b_bytes;

  assign in_ready     = q_ready;
  assign push         = in_valid && q_ready;
  assign q_push.valid = in_valid;
  assign q_push.ready = push;
  assign b            = in_data.text_byte;

  // hex digit gathering shared by both escape code units
  assign hx        = hex_digit(b);
  assign gather_st = (b < CH_SPACE) ? ST_CTRL : (!hx.ok ? ST_UNI : ST_RUN);
  assign hex_shift = {hex_r[11:0], hx.val};
  assign pl        = plain_byte(b);
  assign es        = esc_byte(b);

  // next state and the code units to emit
  always_comb begin
    phase_nxt = phase_r;
    hex_nxt   = hex_r;
    held_nxt  = held_r;
    st        = ST_RUN;
    pre       = 1'b0;
    raw_en    = 1'b0;
    raw       = b;
    cp_en     = 1'b0;
    cp        = '0;
    if (in_data.op == OP_END) begin
      st = ST_UNTERM;
    end else begin
      case (phase_r)
        PH_ESC: begin
          st        = es.status;
          raw_en    = es.emit;
          raw       = es.data;
          phase_nxt = es.to_hex ? PH_HEX0 : PH_NORMAL;
          if (es.to_hex) hex_nxt = '0;
        end
        PH_HEX0, PH_HEX1, PH_HEX2, PH_LOW0, PH_LOW1, PH_LOW2: begin
          st      = gather_st;
          hex_nxt = hex_shift;
          case (phase_r)
            PH_HEX0: phase_nxt = PH_HEX1;
            PH_HEX1: phase_nxt = PH_HEX2;
            PH_HEX2: phase_nxt = PH_HEX3;
            PH_LOW0: phase_nxt = PH_LOW1;
            PH_LOW1: phase_nxt = PH_LOW2;
            default: phase_nxt = PH_LOW3;
          endcase
        end
        PH_HEX3, PH_LOW3: begin
          st        = gather_st;
          hex_nxt   = hex_shift;
          phase_nxt = PH_NORMAL;
          cp_en     = 1'b1;
          cp        = {5'd0, hex_shift};
          if (phase_r == PH_LOW3 && hex_shift[15:10] == 6'b110111) begin
            // completed surrogate pair
            cp = 21'h10000 + {1'b0, held_r, hex_shift[9:0]};
          end else begin
            // unpaired high surrogate is replaced before this code
            pre = (phase_r == PH_LOW3);
            if (hex_shift[15:10] == 6'b110110) begin
              cp_en     = 1'b0;
              held_nxt  = hex_shift[9:0];
              phase_nxt = PH_HELD;
            end else if (hex_shift[15:10] == 6'b110111) begin
              cp = CP_REPL;
            end
          end
        end
        PH_HELD: begin
          if (b == CH_BSLASH) begin
            phase_nxt = PH_HELD_ESC;
          end else begin
            pre       = 1'b1;
            st        = pl.status;
            raw_en    = pl.emit;
            phase_nxt = PH_NORMAL;
          end
        end
        PH_HELD_ESC: begin
          if (b == CH_U) begin
            phase_nxt = PH_LOW0;
            hex_nxt   = '0;
          end else begin
            pre       = 1'b1;
            st        = es.status;
            raw_en    = es.emit;
            raw       = es.data;
            phase_nxt = PH_NORMAL;
          end
        end
        default: begin
          st        = pl.status;
          raw_en    = pl.emit;
          phase_nxt = pl.to_esc ? PH_ESC : PH_NORMAL;
        end
      endcase
    end
    // any end status clears the state; errors drop the bytes
    if (st != ST_RUN) begin
      phase_nxt = PH_NORMAL;
      hex_nxt   = '0;
      held_nxt  = '0;
      if (st != ST_CLOSED) begin
        pre    = 1'b0;
        raw_en = 1'b0;
        cp_en  = 1'b0;
      end
    end
  end

  // utf-8 of the main code unit
  assign enc = utf8_enc(cp);

  always_comb begin
    b_bytes = enc.bytes;
    b_len   = '0;
    if (raw_en) begin
      b_bytes    = '0;
      b_bytes[0] = raw;
      b_len      = 3'd1;
    end else if (cp_en) begin
      b_len = enc.len;
    end
  end

  // pack the replacement prefix and the main bytes into one entry
  always_comb begin
    q_entry        = '0;
    q_entry.status = st;
    q_entry.cnt    = (pre ? 3'd3 : 3'd0) + b_len;
    for (int k = 0; k < MAX_BYTES; k++) begin
      if (pre) begin
        if (k < 3) begin
          q_entry.bytes[k] = REPL_UTF8[k];
        end else if (3'(k - 3) < b_len) begin
          q_entry.bytes[k] = b_bytes[k - 3];
        end
      end else if (k < 4 && 3'(k) < b_len) begin
        q_entry.bytes[k] = b_bytes[k];
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NORMAL;
      hex_r   <= '0;
      held_r  <= '0;
    end else if (push) begin
      phase_r <= phase_nxt;
      hex_r   <= hex_nxt;
      held_r  <= held_nxt;
    end
  end

  `JSU_ASSERT_NEXT(a_end_resets_phase, push && in_data.op == OP_END, phase_r == PH_NORMAL, "end of text left escape state")
  `JSU_ASSERT(a_error_drops_bytes, (push && q_entry.status != ST_RUN && q_entry.status != ST_CLOSED) |-> q_entry.cnt == 3'd0, "error word carries bytes")
  `JSU_ASSERT(a_cnt_bound, push |-> q_entry.cnt <= 3'(MAX_BYTES), "entry byte count too large")

endmodule

// ===== rtl/jsu_queue.sv =====
// short queue of decoded entries between front and back
// depends on jsu_pkg and json_string_unescape_top_macros.svh
`include "json_string_unescape_top_macros.svh"

module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  jsu_hs_t    push,
  output logic       push_ready,
  input  jsu_entry_t wr_entry,
  output logic       head_valid,
  output jsu_entry_t head,
  input  logic       pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_entry_t     mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push.ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_entry;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  `JSU_ASSERT(a_q_bound, count_r <= CW'(DEPTH), "queue fill beyond depth")
  `JSU_ASSERT(a_q_no_overrun, push.ready |-> push_ready && push.valid, "push into full queue")
  `JSU_ASSERT(a_q_no_underrun, pop |-> head_valid, "pop from empty queue")

endmodule

// ===== rtl/jsu_back.sv =====
// back end: walks each entry byte by byte into the output register
// depends on jsu_pkg and json_string_unescape_top_macros.svh
`include "json_string_unescape_top_macros.svh"

module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  jsu_entry_t head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output jsu_out_t   out_data
);

  logic       out_valid_r;
  jsu_out_t   out_r, out_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] nres;
  logic       load;
  logic       is_last;

  assign nres    = (head.cnt == '0) ? 3'd1 : head.cnt;
  assign load    = head_valid && (!out_valid_r || out_ready);
  assign is_last = (idx_r + 3'd1 == nres);
  assign pop     = load && is_last;

  // next result word from the head entry
  always_comb begin
    out_nxt            = '0;
    out_nxt.byte_valid = (head.cnt != '0);
    out_nxt.out_byte   = (head.cnt != '0) ? head.bytes[idx_r] : 8'd0;
    out_nxt.status     = head.status;
    out_nxt.last       = is_last;
    idx_nxt            = idx_r;
    if (pop) idx_nxt = '0;
    else if (load) idx_nxt = idx_r + 3'd1;
  end

  // output register and byte index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `JSU_ASSERT(a_empty_is_last, (out_valid_r && !out_r.byte_valid) |-> out_r.last, "empty result not last")
  `JSU_ASSERT(a_error_no_byte, (out_valid_r && out_r.status != ST_RUN && out_r.status != ST_CLOSED) |-> !out_r.byte_valid, "error word carries a byte")
  `JSU_ASSERT_NEXT(a_word_continues, out_valid_r && out_ready && !out_r.last, out_valid_r, "gap inside one word's results")

endmodule

// ===== rtl/json_string_unescape_top.sv =====
// top level of the json string unescape block
// depends on jsu_pkg, jsu_front, jsu_queue and jsu_back
//
// Decodes the body of a JSON string, one byte per input word, into UTF-8
// result words. The front end takes a new word every cycle while the queue
// has room and resolves escapes and surrogate pairs in that cycle; the back
// end emits one result word per cycle while out_ready is high, from the
// queue through its output register. A word that yields one result (plain
// bytes, simple escapes, hex digits, errors) therefore sustains one word
// per cycle; a word that yields n bytes (n up to 6, for \u escapes and
// replaced surrogates) holds the output until all n bytes are taken, and
// the queue of QUEUE_DEPTH entries lets the input run ahead meanwhile. Each
// result passes through a queue entry and the output register in turn.
// After the closing quote, end of text or any error the decoder is back in
// its start state for the next string.

module json_string_unescape_top
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  jsu_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output jsu_out_t out_data
);

  jsu_entry_t q_entry;
  jsu_entry_t head;
  jsu_hs_t    q_push;
  logic       q_ready;
  logic       head_valid;
  logic       pop;

  // escape tracking and entry build
  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_entry  (q_entry),
    .q_push   (q_push),
    .q_ready  (q_ready)
  );

  // decoupling queue
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .wr_entry   (q_entry),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // byte serialiser and output register
  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
